// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the palette quantizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/npc_pkg.sv =====
// Types, constants and helpers of the nearest palette color quantizer.
package npc_pkg;

    localparam int PALETTE_ENTRIES = 64;
    localparam int IDX_W           = 6;
    localparam int COUNT_W         = 7;
    localparam int CHAN_W          = 8;
    localparam int SQ_W            = 2 * CHAN_W;
    localparam int DIST_W          = SQ_W + 2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(PALETTE_ENTRIES);
    localparam logic [DIST_W-1:0]  DIST_MAX    = {DIST_W{1'b1}};

    typedef struct packed {
        logic              req_type;
        logic [IDX_W-1:0]  entry_index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } npc_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]  match_index;
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
    } npc_out_t;

    // One beat moving down the cell row: the item plus the best match so far.
    typedef struct packed {
        logic              valid;
        npc_in_t           item;
        logic [DIST_W-1:0] best_dist;
        npc_out_t          best;
    } npc_beat_t;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

// ===== rtl/npc_cell.sv =====
// One palette cell: holds one entry, scores the passing pixel, hands the beat on.
module npc_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [npc_pkg::IDX_W-1:0] cell_idx,
    input  logic                  active,
    input  npc_pkg::npc_beat_t    beat_in,
    output npc_pkg::npc_beat_t    beat_out
);
    import npc_pkg::*;

    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;
    logic              load_hit;
    logic              take;
    logic [DIST_W-1:0] score;
    npc_beat_t         beat_next;
    logic              valid_reg;
    npc_in_t           item_reg;
    logic [DIST_W-1:0] best_dist_reg;
    npc_out_t          best_reg;

    assign load_hit = beat_in.valid && (beat_in.item.req_type == REQ_LOAD)
                      && (beat_in.item.entry_index == cell_idx);

    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            red_reg   <= beat_in.item.red;
            green_reg <= beat_in.item.green;
            blue_reg  <= beat_in.item.blue;
        end
    end

    always_comb
    begin
        score = DIST_W'(sq_diff(beat_in.item.red, red_reg))
              + DIST_W'(sq_diff(beat_in.item.green, green_reg))
              + DIST_W'(sq_diff(beat_in.item.blue, blue_reg));
        // Strict compare keeps the lowest index on ties.
        take = beat_in.valid && (beat_in.item.req_type == REQ_PIXEL) && active
               && (score < beat_in.best_dist);
        beat_next = beat_in;
        if (take)
        begin
            beat_next.best_dist        = score;
            beat_next.best.match_index = cell_idx;
            beat_next.best.out_red     = red_reg;
            beat_next.best.out_green   = green_reg;
            beat_next.best.out_blue    = blue_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= beat_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= beat_next.item;
        best_dist_reg <= beat_next.best_dist;
        best_reg      <= beat_next.best;
    end

    assign beat_out = {valid_reg, item_reg, best_dist_reg, best_reg};

endmodule

// ===== rtl/nearest_palette_color_top.sv =====
// Top level of the nearest palette color quantizer: cell row and result register.
//
// Input: item is taken at a clock edge with start high and busy low. busy stays
// low, so one item (load or pixel) may be started in every cycle.
// A load item writes one palette entry and returns nothing. A pixel item
// returns the nearest searched entry (squared RGB distance, lowest index on
// ties): done pulses for one cycle with result holding index and color.
// A pixel passes the register in each palette cell (64 cells) and then the
// result register, which raises done; nothing in the row can stall it.
// Throughput is one item per cycle; loads and pixels travel down the same cell
// row, so every pixel sees exactly the loads started before it.
// cfg_we/cfg_data write palette_count (entries searched from index zero;
// zero acts as one, above 64 as 64). Write it only while no pixel is in flight.
// Reset clears the row's beat flags and sets palette_count to 64; palette
// contents are undefined until loaded. The receiver cannot stall: done is a
// one-cycle strobe per pixel, and result holds only until the next pixel's.
module nearest_palette_color_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  npc_pkg::npc_in_t              item,
    output logic                          done,
    output npc_pkg::npc_out_t             result,
    input  logic                          cfg_we,
    input  logic [npc_pkg::COUNT_W-1:0]   cfg_data
);
    import npc_pkg::*;
    `include "assert_macros.svh"

    logic [COUNT_W-1:0] count_reg;
    npc_beat_t          chain [PALETTE_ENTRIES+1];
    logic               done_reg;
    npc_out_t           result_reg;
    logic               tail_pixel;
    logic               match_in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_data;
        end
    end

    assign busy = 1'b0;

    always_comb
    begin
        chain[0].valid     = start && !busy;
        chain[0].item      = item;
        chain[0].best_dist = DIST_MAX;
        chain[0].best      = '0;
    end

    for (genvar g = 0; g < PALETTE_ENTRIES; g++)
    begin : g_cell
        logic active;
        // Cell zero always searches, so a count of zero behaves as one.
        assign active = (g == 0) || (COUNT_W'(g) < count_reg);

        npc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(g)),
            .active   (active),
            .beat_in  (chain[g]),
            .beat_out (chain[g+1])
        );
    end

    assign tail_pixel = chain[PALETTE_ENTRIES].valid
                        && (chain[PALETTE_ENTRIES].item.req_type == REQ_PIXEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tail_pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_pixel)
        begin
            result_reg <= chain[PALETTE_ENTRIES].best;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    assign match_in_range = (count_reg == '0) || ({1'b0, result.match_index} < count_reg);

    `NPC_ASSERT_NEXT(a_pixel_gives_done, tail_pixel, done, "pixel beat lost at row end")
    `NPC_ASSERT_NEXT(a_done_only_for_pixel, !tail_pixel, !done, "result strobe without pixel")
    `NPC_ASSERT_NOW(a_match_in_range, done, match_in_range, "match index beyond searched count")

endmodule
